@@ hw/rtl/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg: shared types and constants of the fixed block pool allocator
// Field widths, status and register codes, controller states and the
// request/response bundle of the statistics unit.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Field and register widths
  localparam int CountW   = 9;    // block_count, free_total
  localparam int BytesW   = 16;   // block_bytes
  localparam int IndexW   = 8;    // block_index, granted_index
  localparam int UsedW    = 24;   // used_bytes
  localparam int PctW     = 7;    // free_percent
  localparam int RemW     = 16;   // free_total * 100 fits here
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Stream payload widths
  localparam int InDataW  = 8;    // block_index
  localparam int InUserW  = 1;    // operation
  localparam int OutDataW = 48;   // granted, free_total, used_bytes, free_percent
  localparam int OutUserW = 2;    // status

  localparam int PercentScale = 100;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegBlockCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBlockBytes = 2'd1;

  // Request kinds
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_RANGE  = 2'd2,
    STATUS_DOUBLE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_WAIT = 3'b100
  } state_e;

  typedef struct packed {
    logic              start;
    logic [CountW-1:0] count;
    logic [CountW-1:0] tally;
    logic [BytesW-1:0] bytes;
  } stats_req_t;

  typedef struct packed {
    logic             done;
    logic [UsedW-1:0] used;
    logic [PctW-1:0]  pct;
  } stats_rsp_t;

endpackage

@@ hw/rtl/fbpa_link_mem.sv @@
// ----------------------------------------------------------------------------
// fbpa_link_mem: link and free-flag memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fbpa_link_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 10
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/fbpa_stats.sv @@
// ----------------------------------------------------------------------------
// fbpa_stats: usage statistics
// Multiply used blocks by block size, then divide free_total * 100 by the
// block count with a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbpa_stats (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fbpa_pkg::stats_req_t req_i,
  output fbpa_pkg::stats_rsp_t rsp_o
);

  localparam int StepW = $clog2(fbpa_pkg::PctW);

  logic                          busy_q;
  logic                          done_q;
  logic [StepW-1:0]              step_q;
  logic [fbpa_pkg::UsedW-1:0]    used_q;
  logic [fbpa_pkg::RemW-1:0]     rem_q;
  logic [fbpa_pkg::CountW-1:0]   div_q;
  logic [fbpa_pkg::PctW-1:0]     quo_q;
  logic [fbpa_pkg::CountW-1:0]   used_blocks;
  logic [fbpa_pkg::RemW-1:0]     div_shifted;

  assign used_blocks = req_i.count - req_i.tally;
  assign div_shifted = fbpa_pkg::RemW'(div_q) << step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= StepW'(fbpa_pkg::PctW - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      used_q <= fbpa_pkg::UsedW'(used_blocks) * fbpa_pkg::UsedW'(req_i.bytes);
      rem_q  <= fbpa_pkg::RemW'(32'(req_i.tally) * fbpa_pkg::PercentScale);
      div_q  <= req_i.count;
      quo_q  <= '0;
    end else if (busy_q) begin
      if (rem_q >= div_shifted) begin
        rem_q         <= rem_q - div_shifted;
        quo_q[step_q] <= 1'b1;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.used = used_q;
  assign rsp_o.pct  = quo_q;

endmodule

@@ hw/rtl/fixed_block_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator: free-list allocator for a pool of equal blocks
//
// Requests arrive on the s_axis channel: tuser selects allocate (0) or free
// (1), tdata carries the block to free. Each request yields one result beat on
// m_axis with the status in tuser and the grant and usage figures in tdata.
// The link memory is read at the accepting edge; the EXEC state then updates
// the chain and starts the usage multiply, the bit-serial percentage divide
// follows (one quotient bit per cycle), and the WAIT state then loads the
// output register. One request is in work at a time and tready returns only
// after the load, so a new request is taken only once the last one's result
// has been loaded.
// The result register decouples the two sides: a new request is taken while
// a result still waits, and its result is held back until the receiver has
// taken the earlier beat. A stalled receiver thus stops the block after one
// request in work plus one waiting result.
// Reset (or a block_count write) makes every block free, chain ascending.
// Chain entries never touched since then are tracked by a fill mark, so no
// clearing pass over the memory is needed and requests are taken at once.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
  parameter int NUM_BLOCKS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Requests
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [fbpa_pkg::InDataW-1:0]   s_axis_tdata,   // [7:0] block_index
  input  logic [fbpa_pkg::InUserW-1:0]   s_axis_tuser,   // [0] operation
  // Results
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] granted_index, [16:8] free_total, [40:17] used_bytes,
  // [47:41] free_percent
  output logic [fbpa_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [fbpa_pkg::OutUserW-1:0]  m_axis_tuser,   // [1:0] status
  // Configuration
  input  logic                           cfg_we_i,
  input  logic [fbpa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fbpa_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int IdxW  = $clog2(NUM_BLOCKS);
  localparam int HeadW = $clog2(NUM_BLOCKS + 1);
  localparam int EntW  = HeadW + 1;   // {free flag, link}
  localparam logic [fbpa_pkg::CountW-1:0] ResetCount =
    (NUM_BLOCKS < 256) ? fbpa_pkg::CountW'(NUM_BLOCKS) : fbpa_pkg::CountW'(256);

  // Controller and chain state
  fbpa_pkg::state_e              state_q, state_d;
  logic [HeadW-1:0]              head_q, head_d;
  logic [HeadW-1:0]              fill_q, fill_d;     // first never-popped block
  logic [fbpa_pkg::CountW-1:0]   tally_q, tally_d;
  logic [fbpa_pkg::CountW-1:0]   count_q;
  logic [fbpa_pkg::BytesW-1:0]   bytes_q;
  logic                          op_q;
  logic [fbpa_pkg::IndexW-1:0]   idx_q;
  fbpa_pkg::status_e             status_q, status_d;
  logic [fbpa_pkg::IndexW-1:0]   granted_q, granted_d;

  // Output register
  logic                          out_valid_q;
  logic [fbpa_pkg::OutDataW-1:0] out_data_q;
  logic [fbpa_pkg::OutUserW-1:0] out_user_q;

  // Memory ports
  logic                          rd_en;
  logic [IdxW-1:0]               rd_addr;
  logic [EntW-1:0]               rd_data;
  logic                          wr_en;
  logic [IdxW-1:0]               wr_addr;
  logic [EntW-1:0]               wr_data;

  fbpa_pkg::stats_req_t          stats_req;
  fbpa_pkg::stats_rsp_t          stats_rsp;

  logic                          in_beat;
  logic                          out_free;
  logic                          out_load;
  logic [31:0]                   in_idx_wide;
  logic [31:0]                   idx_wide;
  logic [31:0]                   head_wide;
  logic [HeadW-1:0]              rd_link;
  logic                          rd_flag;
  logic                          head_fresh;
  logic [fbpa_pkg::CountW-1:0]   cfg_count;

  assign s_axis_tready = (state_q == fbpa_pkg::ST_IDLE);
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign out_load      = (state_q == fbpa_pkg::ST_WAIT) & stats_rsp.done & out_free;

  assign in_idx_wide = 32'(s_axis_tdata);
  assign idx_wide    = 32'(idx_q);
  assign head_wide   = 32'(head_q);
  assign rd_link     = rd_data[HeadW-1:0];
  assign rd_flag     = rd_data[HeadW];
  assign head_fresh  = (head_q >= fill_q);

  // Read the entry the request touches: the head on allocate, the block on free
  assign rd_en   = in_beat;
  assign rd_addr = (s_axis_tuser[0] == fbpa_pkg::OpFree) ? in_idx_wide[IdxW-1:0]
                                                         : head_q[IdxW-1:0];

  fbpa_link_mem #(
    .DEPTH (NUM_BLOCKS),
    .AW    (IdxW),
    .DW    (EntW)
  ) u_link_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Saturate the block count to 1..NUM_BLOCKS
  always_comb begin
    cfg_count = cfg_data_i[fbpa_pkg::CountW-1:0];
    if (cfg_count == '0) begin
      cfg_count = fbpa_pkg::CountW'(1);
    end else if (32'(cfg_count) > NUM_BLOCKS) begin
      cfg_count = fbpa_pkg::CountW'(NUM_BLOCKS);
    end
  end

  // Chain update, in the cycle after the memory read
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    fill_d    = fill_q;
    tally_d   = tally_q;
    status_d  = status_q;
    granted_d = granted_q;
    wr_en     = 1'b0;
    wr_addr   = head_q[IdxW-1:0];
    wr_data   = rd_data;
    stats_req = '0;

    unique case (state_q)
      fbpa_pkg::ST_IDLE: begin
        if (in_beat) begin
          state_d = fbpa_pkg::ST_EXEC;
        end
      end
      fbpa_pkg::ST_EXEC: begin
        status_d  = fbpa_pkg::STATUS_OK;
        granted_d = '0;
        if (op_q == fbpa_pkg::OpAlloc) begin
          if (tally_q == '0 || head_wide >= NUM_BLOCKS) begin
            status_d = fbpa_pkg::STATUS_EMPTY;
          end else begin
            // Pop the head; an untouched block links to its successor
            granted_d = head_wide[fbpa_pkg::IndexW-1:0];
            wr_en     = 1'b1;
            wr_addr   = head_q[IdxW-1:0];
            wr_data   = {1'b0, rd_link};
            head_d    = head_fresh ? head_q + 1'b1 : rd_link;
            if (head_fresh) begin
              fill_d = fill_q + 1'b1;
            end
            tally_d = tally_q - 1'b1;
          end
        end else begin
          if (idx_wide >= 32'(count_q)) begin
            status_d = fbpa_pkg::STATUS_RANGE;
          end else if (idx_wide >= 32'(fill_q) || rd_flag) begin
            status_d = fbpa_pkg::STATUS_DOUBLE;
          end else begin
            // Push the block back as the new head
            wr_en   = 1'b1;
            wr_addr = idx_wide[IdxW-1:0];
            wr_data = {1'b1, head_q};
            head_d  = idx_wide[HeadW-1:0];
            tally_d = tally_q + 1'b1;
          end
        end
        stats_req.start = 1'b1;
        stats_req.count = count_q;
        stats_req.tally = tally_d;
        stats_req.bytes = bytes_q;
        state_d = fbpa_pkg::ST_WAIT;
      end
      fbpa_pkg::ST_WAIT: begin
        if (out_load) begin
          state_d = fbpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fbpa_pkg::ST_IDLE;
      end
    endcase
  end

  fbpa_stats u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (stats_req),
    .rsp_o  (stats_rsp)
  );

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbpa_pkg::ST_IDLE;
      head_q  <= '0;
      fill_q  <= '0;
      tally_q <= ResetCount;
      count_q <= ResetCount;
      bytes_q <= fbpa_pkg::BytesW'(64);
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == fbpa_pkg::RegBlockCount) begin
        // Rebuild the chain: everything free, ascending order
        count_q <= cfg_count;
        tally_q <= cfg_count;
        head_q  <= '0;
        fill_q  <= '0;
      end else begin
        head_q  <= head_d;
        fill_q  <= fill_d;
        tally_q <= tally_d;
      end
      if (cfg_we_i && cfg_idx_i == fbpa_pkg::RegBlockBytes) begin
        bytes_q <= cfg_data_i;
      end
    end
  end

  // Request payload and decision
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q  <= s_axis_tuser[0];
      idx_q <= s_axis_tdata;
    end
    status_q  <= status_d;
    granted_q <= granted_d;
  end

  // Result register: hold until taken, load when free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {stats_rsp.pct, stats_rsp.used, tally_q, granted_q};
      out_user_q <= status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

@@ tb/tb_fixed_block_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator: self-checking bench for the block allocator
// Drives allocate and free requests on the request stream and predicts every
// result beat with a shadow copy of the free chain. The run has a directed
// opening, then random phases under different pool sizes and block sizes.
// Both sides stall at random under idle_on; each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  localparam int PoolBlocks   = 256;
  localparam int SettleCycles = 20;    // longer than the request latency
  localparam int StallLimit   = 1000;  // cycles without any beat before giving up

  // Register indexes that the block has no register behind
  localparam logic [CfgIdxW-1:0] RegUnmappedA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegUnmappedB = 2'd3;

  typedef struct packed {
    status_e             status;
    logic [IndexW-1:0]   granted;
    logic [CountW-1:0]   free_total;
    logic [UsedW-1:0]    used;
    logic [PctW-1:0]     pct;
  } pool_result_t;

  // --------------------------------------------------------------------------
  // Shadow of the free chain plus the queue of results still owed by the block
  // --------------------------------------------------------------------------
  class pool_scoreboard;
    logic [CountW-1:0]  count_reg;
    logic [BytesW-1:0]  bytes_reg;
    logic [CountW-1:0]  next_link [PoolBlocks];
    logic [CountW-1:0]  head;
    int unsigned        tally;
    bit                 is_free [PoolBlocks];
    pool_result_t       owed_q [$];
    int unsigned        errors;

    function new();
      count_reg = CountW'(PoolBlocks);
      bytes_reg = BytesW'(64);
      errors    = 0;
      rebuild_chain();
    endfunction

    // Pool size as the block sees it: zero acts as one, large values clip
    function int unsigned live_blocks();
      if (count_reg == 0) return 1;
      if (count_reg > PoolBlocks) return PoolBlocks;
      return count_reg;
    endfunction

    // Every block free, chain ascending from block 0
    function void rebuild_chain();
      for (int i = 0; i < PoolBlocks; i++) begin
        next_link[i] = CountW'(i + 1);
        is_free[i]   = 1'b1;
      end
      head  = '0;
      tally = live_blocks();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegBlockCount: begin
          count_reg = data[CountW-1:0];
          rebuild_chain();
        end
        RegBlockBytes: begin
          bytes_reg = data[BytesW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function bit is_idle();
      return owed_q.size() == 0;
    endfunction

    // Random block that is currently handed out, or -1 when none is
    function int pick_in_use();
      int busy [$];
      int unsigned n;
      n = live_blocks();
      for (int i = 0; i < n; i++) begin
        if (!is_free[i]) busy.push_back(i);
      end
      if (busy.size() == 0) return -1;
      return busy[$urandom_range(0, busy.size() - 1)];
    endfunction

    // Apply one accepted request to the shadow chain and queue its result
    function void note_request(logic op, logic [IndexW-1:0] idx);
      pool_result_t r;
      int unsigned  n;
      n         = live_blocks();
      r.status  = STATUS_OK;
      r.granted = '0;
      if (op == OpAlloc) begin
        if (tally == 0 || head >= PoolBlocks) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.granted          = head[IndexW-1:0];
          is_free[r.granted] = 1'b0;
          head               = next_link[r.granted];
          tally--;
        end
      end else if (idx >= n) begin
        r.status = STATUS_RANGE;
      end else if (is_free[idx]) begin
        r.status = STATUS_DOUBLE;
      end else begin
        is_free[idx]   = 1'b1;
        next_link[idx] = head;
        head           = CountW'(idx);
        tally++;
      end
      r.free_total = CountW'(tally);
      r.used       = UsedW'((n - tally) * bytes_reg);
      r.pct        = PctW'((tally * PercentScale) / n);
      owed_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [OutUserW-1:0] status, logic [OutDataW-1:0] data);
      pool_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual status %0d data %h",
                 $time, status, data);
        return;
      end
      want = owed_q.pop_front();
      compare_field("status",        want.status,     status);
      compare_field("granted_index", want.granted,    data[7:0]);
      compare_field("free_total",    want.free_total, data[16:8]);
      compare_field("used_bytes",    want.used,       data[40:17]);
      compare_field("free_percent",  want.pct,        data[47:41]);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;   // [7:0] block_index
  logic [InUserW-1:0]   s_axis_tuser  = '0;   // [0] operation
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [7:0] granted_index, [16:8] free_total, [40:17] used_bytes, [47:41] free_percent
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [OutUserW-1:0]  m_axis_tuser;         // [1:0] status
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;

  fixed_block_pool_allocator #(
    .NUM_BLOCKS(PoolBlocks)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  pool_scoreboard sb;
  bit idle_on = 1'b1;   // per phase: let both sides insert random gaps
  bit filling = 1'b1;   // random phases lean toward allocate while set

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Send one request beat. Keep tvalid high across back-to-back beats so it
  // never gets two assignments in one step; drop it only for a gap.
  task automatic push_request(input logic op, input logic [IndexW-1:0] idx);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= idx;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_request(op, idx);
  endtask

  // Drop tvalid, let every owed result come back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (!sb.is_idle()) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write both registers plus one unmapped index while the block is idle.
  // Bits above the 9-bit count field are filled with random junk.
  task automatic configure(input int unsigned count, input int unsigned bytes);
    logic [CfgDataW-1:0] count_word;
    logic [CfgDataW-1:0] junk;
    logic [CfgIdxW-1:0]  stray_idx;
    count_word = CfgDataW'(count & 'h1FF) | CfgDataW'($urandom_range(0, 127) << CountW);
    junk       = CfgDataW'($urandom);
    stray_idx  = $urandom_range(0, 1) ? RegUnmappedA : RegUnmappedB;
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegBlockBytes;
    cfg_data_i <= CfgDataW'(bytes);
    @(posedge clk_i);
    sb.write_reg(RegBlockBytes, CfgDataW'(bytes));
    cfg_idx_i  <= RegBlockCount;
    cfg_data_i <= count_word;
    @(posedge clk_i);
    sb.write_reg(RegBlockCount, count_word);
    cfg_idx_i  <= stray_idx;
    cfg_data_i <= junk;
    @(posedge clk_i);
    sb.write_reg(stray_idx, junk);
    cfg_we_i   <= 1'b0;
  endtask

  // Random traffic that swings the pool between full and empty. Most frees
  // name a block that is really handed out; the rest name a random index or
  // one past the pool, so double frees and out-of-range frees occur too.
  task automatic run_random(input int unsigned items);
    int unsigned n;
    int          busy_blk;
    int unsigned roll;
    logic        op;
    logic [IndexW-1:0] idx;
    for (int unsigned k = 0; k < items; k++) begin
      n = sb.live_blocks();
      if (sb.tally == 0) filling = 1'b0;
      else if (sb.tally == n) filling = 1'b1;
      else if ($urandom_range(0, 63) == 0) filling = !filling;
      op   = ($urandom_range(0, 99) < (filling ? 80 : 20)) ? OpAlloc : OpFree;
      idx  = IndexW'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (op == OpFree) begin
        busy_blk = sb.pick_in_use();
        if (roll < 80 && busy_blk >= 0) idx = IndexW'(busy_blk);
        else if (roll >= 90 && n < PoolBlocks) idx = IndexW'($urandom_range(n, 255));
      end
      push_request(op, idx);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall at random, check each accepted beat
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = idle_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no beat moves on either side for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset pool: 256 blocks of 64 bytes, all free
    push_request(OpFree,  8'd0);     // double free, every block starts free
    push_request(OpFree,  8'd255);   // double free at the top index
    push_request(OpAlloc, 8'd255);   // index ignored on allocate, grant block 0
    push_request(OpAlloc, 8'd0);     // grant block 1
    push_request(OpFree,  8'd0);     // block 0 becomes the head again
    push_request(OpAlloc, 8'd0);     // last freed comes back first
    push_request(OpFree,  8'd1);
    push_request(OpFree,  8'd1);     // second free of the same block

    // Tiny pool with the largest block size: run it dry and refill
    configure(3, 65535);
    push_request(OpAlloc, 8'd0);
    push_request(OpAlloc, 8'd0);
    push_request(OpAlloc, 8'd0);
    push_request(OpAlloc, 8'd0);     // pool empty
    push_request(OpFree,  8'd3);     // just past the pool
    push_request(OpFree,  8'd255);   // far past the pool
    push_request(OpFree,  8'd2);
    push_request(OpFree,  8'd0);
    push_request(OpAlloc, 8'd0);     // grant 0, then 2 behind it
    push_request(OpAlloc, 8'd0);
    push_request(OpAlloc, 8'd0);     // empty again

    // Count of zero behaves as a one-block pool
    configure(0, 1);
    push_request(OpAlloc, 8'd0);
    push_request(OpAlloc, 8'd0);
    push_request(OpFree,  8'd1);
    push_request(OpFree,  8'd0);

    // Random phases over a spread of pool and block sizes
    configure(256, 65535);                     idle_on = 1'b1; run_random(460);
    configure(1, 1);                           idle_on = 1'b1; run_random(80);
    configure(511, $urandom_range(1, 65535));  idle_on = 1'b0; run_random(200);
    configure(5, $urandom_range(1, 65535));    idle_on = 1'b1; run_random(140);
    configure($urandom_range(1, 256), $urandom_range(0, 65535));
    idle_on = 1'b1; run_random(180);
    configure(0, 65535);                       idle_on = 1'b0; run_random(60);
    configure(100, 300);                       idle_on = 1'b1; run_random(180);
    configure(256, 64);                        idle_on = 1'b0; run_random(120);

    idle_on = 1'b1;
    drain();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_link_mem.sv
hw/rtl/fbpa_stats.sv
hw/rtl/fixed_block_pool_allocator.sv
tb/tb_fixed_block_pool_allocator.sv
